FILE: rtl/tcvg_pkg.sv
// Shared types, constants and helpers for the torus cell vertex generator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tcvg_pkg;

  localparam int MAX_DIVISIONS = 1024;
  localparam int FRACTION_BITS = 8;

  localparam int IDX_W = 10;
  localparam int CNT_W = 11;
  localparam int RAD_W = 16;
  localparam int POS_W = 19;
  localparam int TEX_W = 17;
  localparam int VTX_W = 3;

  // Divider: index << 16 over count, three quotient bits per stage
  localparam int DIV_NUM_W  = CNT_W + 16;
  localparam int DIV_BPS    = 3;
  localparam int DIV_STAGES = DIV_NUM_W / DIV_BPS;

  // Datapath after the divider: four sine stages, five coordinate stages
  localparam int SIN_LAT = 4;
  localparam int TAIL_STAGES = SIN_LAT + 5;

  localparam int XZ_SHIFT = 38 - FRACTION_BITS;
  localparam int Y_SHIFT  = 23 - FRACTION_BITS;

  localparam int SIN_C0 = 41906;
  localparam int SIN_C1 = 4569;
  localparam int SIN_C2 = 102873;

  localparam logic [VTX_W-1:0] VTX_FIRST = 3'd0;
  localparam logic [VTX_W-1:0] VTX_LAST  = 3'd5;

  localparam logic [1:0] REG_TUBE  = 2'd0;
  localparam logic [1:0] REG_RING  = 2'd1;
  localparam logic [1:0] REG_SLICE = 2'd2;
  localparam logic [1:0] REG_STACK = 2'd3;

  typedef struct packed {
    logic [VTX_W-1:0] vtx;
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
  } side_t;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
    if (c == '0) return CNT_W'(1);
    if (c > CNT_W'(MAX_DIVISIONS)) return CNT_W'(MAX_DIVISIONS);
    return c;
  endfunction

  // Triangle order: (t,p) (t,p') (t',p) (t,p') (t',p') (t',p)
  function automatic logic next_slice(input logic [VTX_W-1:0] k);
    return (k == 3'd2) || (k == 3'd4) || (k == 3'd5);
  endfunction

  function automatic logic next_stack(input logic [VTX_W-1:0] k);
    return (k == 3'd1) || (k == 3'd3) || (k == 3'd4);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/tcvg_div.sv
// Pipelined restoring divider: (index << 16) / count, three bits per stage.
// Depends on tcvg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tcvg_div (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic [tcvg_pkg::CNT_W-1:0]         idx_i,
  input  wire logic [tcvg_pkg::CNT_W-1:0]         cnt_i,
  output logic      [tcvg_pkg::DIV_NUM_W-1:0]     quo_o
);

  localparam int NW = tcvg_pkg::DIV_NUM_W;
  localparam int CW = tcvg_pkg::CNT_W;
  localparam int NS = tcvg_pkg::DIV_STAGES;

  logic [CW-1:0] rem_r [NS];
  logic [NW-1:0] num_r [NS];
  logic [NW-1:0] quo_r [NS];
  logic [CW-1:0] den_r [NS];

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic [CW-1:0] src_rem, src_den, r;
    logic [NW-1:0] src_num, src_quo, n, q;
    logic [CW:0]   r2;

    if (g == 0) begin : g_head
      assign src_rem = '0;
      assign src_num = {idx_i, 16'd0};
      assign src_quo = '0;
      assign src_den = cnt_i;
    end else begin : g_body
      assign src_rem = rem_r[g-1];
      assign src_num = num_r[g-1];
      assign src_quo = quo_r[g-1];
      assign src_den = den_r[g-1];
    end

    always_comb begin
      r  = src_rem;
      n  = src_num;
      q  = src_quo;
      r2 = '0;
      for (int s = 0; s < tcvg_pkg::DIV_BPS; s++) begin
        r2 = {r, n[NW-1]};
        if (r2 >= {1'b0, src_den}) begin
          r = CW'(r2 - {1'b0, src_den});
          q = {q[NW-2:0], 1'b1};
        end else begin
          r = r2[CW-1:0];
          q = {q[NW-2:0], 1'b0};
        end
        n = {n[NW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= r;
        num_r[g] <= n;
        quo_r[g] <= q;
        den_r[g] <= src_den;
      end
    end
  end

  assign quo_o = quo_r[NS-1];

endmodule
`default_nettype wire

FILE: rtl/tcvg_sin.sv
// Four-stage sine of a 16-bit turn fraction, Q2.15 result (-32768..32768).
// Quarter-wave integer polynomial; depends on tcvg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tcvg_sin (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [15:0]        ang_i,
  output logic signed [16:0]      sin_o
);

  logic [14:0] zl, z;
  logic [29:0] zz;
  logic [27:0] p1;
  logic [30:0] p2;
  logic [31:0] p3;

  logic [1:0]  quad1_r, quad2_r, quad3_r;
  logic [14:0] z1_r, z2_r, z3_r;
  logic [14:0] sq1_r, sq2_r;
  logic [15:0] u_r;
  logic [16:0] w_r;
  logic signed [16:0] s_r;

  // mirror odd quadrants
  assign zl = {1'b0, ang_i[13:0]};
  assign z  = ang_i[14] ? 15'(15'd16384 - zl) : zl;
  assign zz = {15'd0, z} * {15'd0, z};
  assign p1 = 28'(tcvg_pkg::SIN_C1) * {13'd0, sq1_r};
  assign p2 = {16'd0, sq2_r} * {15'd0, u_r};
  assign p3 = {17'd0, z3_r} * {15'd0, w_r};

  always_ff @(posedge clk) begin
    if (en) begin
      quad1_r <= ang_i[15:14];
      z1_r    <= z;
      sq1_r   <= zz[28:14];
      quad2_r <= quad1_r;
      z2_r    <= z1_r;
      sq2_r   <= sq1_r;
      u_r     <= 16'(17'(tcvg_pkg::SIN_C0) - {3'd0, p1[27:14]});
      quad3_r <= quad2_r;
      z3_r    <= z2_r;
      w_r     <= 17'(18'(tcvg_pkg::SIN_C2) - {1'b0, p2[30:14]});
      s_r     <= quad3_r[1] ? -$signed(p3[31:15]) : $signed(p3[31:15]);
    end
  end

  assign sin_o = s_r;

endmodule
`default_nettype wire

FILE: rtl/torus_cell_vertex_generator.sv
// Top level: cell sequencer, quotient dividers, sine units, coordinate math.
// Depends on tcvg_pkg, tcvg_div, tcvg_sin.
//
//  channel | direction | handshake            | word
//  in_     | input     | in_valid / in_ready  | slice_index, stack_index
//  out_    | output    | out_valid / out_ready| pos xyz, tex uv, vertex_number, last
//  cfg_    | input     | APB psel/penable     | tube/ring radius, slice/stack count
//
// A new cell can be taken while the last vertex of the current one is issued; the
// sequencer issues one vertex a cycle unless the output stalls. An accepted cell is
// registered, then passes 9 divider, 4 sine and 5 coordinate stages to the output.
// The whole pipeline holds while the output word waits; nothing drops or repeats.
// rst_n is synchronous; it clears valid bits and sequencer and loads config defaults.
`timescale 1ns / 1ps
`default_nettype none
module torus_cell_vertex_generator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [9:0]  in_slice_index,
  input  wire logic [9:0]  in_stack_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [18:0]      out_pos_x,
  output logic [18:0]      out_pos_y,
  output logic [18:0]      out_pos_z,
  output logic [16:0]      out_tex_u,
  output logic [16:0]      out_tex_v,
  output logic [2:0]       out_vertex_number,
  output logic             out_last,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int NS = tcvg_pkg::DIV_STAGES;
  localparam int NT = tcvg_pkg::TAIL_STAGES;
  localparam int NW = tcvg_pkg::DIV_NUM_W;

  // ---------------- configuration ----------------
  logic [15:0] tube_r, ring_r;
  logic [10:0] slice_cnt_r, stack_cnt_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tube_r      <= 16'd256;
      ring_r      <= 16'd512;
      slice_cnt_r <= 11'd16;
      stack_cnt_r <= 11'd16;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        tcvg_pkg::REG_TUBE:  tube_r      <= cfg_pwdata[15:0];
        tcvg_pkg::REG_RING:  ring_r      <= cfg_pwdata[15:0];
        tcvg_pkg::REG_SLICE: slice_cnt_r <= cfg_pwdata[10:0];
        tcvg_pkg::REG_STACK: stack_cnt_r <= cfg_pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      tcvg_pkg::REG_TUBE:  cfg_prdata = {16'd0, tube_r};
      tcvg_pkg::REG_RING:  cfg_prdata = {16'd0, ring_r};
      tcvg_pkg::REG_SLICE: cfg_prdata = {21'd0, slice_cnt_r};
      tcvg_pkg::REG_STACK: cfg_prdata = {21'd0, stack_cnt_r};
      default:             cfg_prdata = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  logic       en;
  logic       busy_r;
  logic [2:0] k_r;
  logic [9:0] cell_si_r, cell_ti_r;
  logic       in_acc;
  logic [10:0] idx_u, idx_v;

  logic [NT-1:0] vt_r;
  assign en = out_ready | ~vt_r[NT-1];

  assign in_ready = en & (~busy_r | (k_r == tcvg_pkg::VTX_LAST));
  assign in_acc   = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= tcvg_pkg::VTX_FIRST;
    end else if (in_acc) begin
      busy_r <= 1'b1;
      k_r    <= tcvg_pkg::VTX_FIRST;
    end else if (en && busy_r) begin
      if (k_r == tcvg_pkg::VTX_LAST) begin
        busy_r <= 1'b0;
      end else begin
        k_r <= 3'(k_r + 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cell_si_r <= in_slice_index;
      cell_ti_r <= in_stack_index;
    end
  end

  assign idx_u = {1'b0, cell_si_r} + {10'd0, tcvg_pkg::next_slice(k_r)};
  assign idx_v = {1'b0, cell_ti_r} + {10'd0, tcvg_pkg::next_stack(k_r)};

  // ---------------- dividers ----------------
  logic [NW-1:0] qu, qv;
  logic [NS-1:0] vd_r;
  logic [2:0]    kd_r [NS];

  tcvg_div u_div_u (
    .clk   (clk),
    .en    (en),
    .idx_i (idx_u),
    .cnt_i (tcvg_pkg::eff_count(slice_cnt_r)),
    .quo_o (qu)
  );

  tcvg_div u_div_v (
    .clk   (clk),
    .en    (en),
    .idx_i (idx_v),
    .cnt_i (tcvg_pkg::eff_count(stack_cnt_r)),
    .quo_o (qv)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= '0;
    end else if (en) begin
      vd_r <= {vd_r[NS-2:0], busy_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kd_r[0] <= k_r;
      for (int i = 1; i < NS; i++) kd_r[i] <= kd_r[i-1];
    end
  end

  // ---------------- side info and valid line ----------------
  tcvg_pkg::side_t side_in;
  tcvg_pkg::side_t side_r [NT];

  assign side_in.vtx   = kd_r[NS-1];
  assign side_in.tex_u = (qu > NW'(65536)) ? 17'd65536 : qu[16:0];
  assign side_in.tex_v = (qv > NW'(65536)) ? 17'd65536 : qv[16:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt_r <= '0;
    end else if (en) begin
      vt_r <= {vt_r[NT-2:0], vd_r[NS-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int i = 1; i < NT; i++) side_r[i] <= side_r[i-1];
    end
  end

  // ---------------- sines ----------------
  logic signed [16:0] sin_t, cos_t, sin_p, cos_p;

  tcvg_sin u_sin_t (.clk(clk), .en(en), .ang_i(qu[15:0]), .sin_o(sin_t));
  tcvg_sin u_cos_t (.clk(clk), .en(en), .ang_i(16'(qu[15:0] + 16'd16384)), .sin_o(cos_t));
  tcvg_sin u_sin_p (.clk(clk), .en(en), .ang_i(qv[15:0]), .sin_o(sin_p));
  tcvg_sin u_cos_p (.clk(clk), .en(en), .ang_i(16'(qv[15:0] + 16'd16384)), .sin_o(cos_p));

  // ---------------- coordinates ----------------
  logic signed [33:0] rc_r, rs_r, w_r;
  logic signed [16:0] st1_r, ct1_r, st2_r, ct2_r;
  logic signed [18:0] y2_r, y3_r, y4_r, y5_r;
  logic signed [33:0] px_lo_r, pz_lo_r;
  logic signed [34:0] px_hi_r, pz_hi_r;
  logic signed [50:0] xs_r, zs_r;
  logic signed [18:0] x5_r, z5_r;
  logic signed [33:0] y_rnd;
  logic signed [33:0] y_sh;
  logic signed [50:0] x_rnd, z_rnd;
  logic signed [50:0] x_sh, z_sh;

  function automatic logic signed [18:0] sat19(input logic signed [50:0] v);
    if (v > 51'sd262143) return 19'sh3FFFF;
    if (v < -51'sd262144) return 19'sh40000;
    return v[18:0];
  endfunction

  assign y_rnd = rs_r + 34'(1 << (tcvg_pkg::Y_SHIFT - 1));
  assign y_sh  = y_rnd >>> tcvg_pkg::Y_SHIFT;
  assign x_rnd = xs_r + 51'(64'd1 << (tcvg_pkg::XZ_SHIFT - 1));
  assign z_rnd = zs_r + 51'(64'd1 << (tcvg_pkg::XZ_SHIFT - 1));
  assign x_sh  = x_rnd >>> tcvg_pkg::XZ_SHIFT;
  assign z_sh  = z_rnd >>> tcvg_pkg::XZ_SHIFT;

  always_ff @(posedge clk) begin
    if (en) begin
      rc_r  <= $signed({1'b0, tube_r}) * cos_p;
      rs_r  <= $signed({1'b0, tube_r}) * sin_p;
      st1_r <= sin_t;
      ct1_r <= cos_t;

      w_r   <= $signed({3'd0, ring_r, 15'd0}) + rc_r;
      y2_r  <= sat19(51'(y_sh));
      st2_r <= st1_r;
      ct2_r <= ct1_r;

      // split w so each product stays near 17x17
      px_lo_r <= $signed({1'b0, w_r[15:0]}) * ct2_r;
      pz_lo_r <= $signed({1'b0, w_r[15:0]}) * st2_r;
      px_hi_r <= $signed(w_r[33:16]) * ct2_r;
      pz_hi_r <= $signed(w_r[33:16]) * st2_r;
      y3_r    <= y2_r;

      xs_r <= (51'(px_hi_r) <<< 16) + 51'(px_lo_r);
      zs_r <= (51'(pz_hi_r) <<< 16) + 51'(pz_lo_r);
      y4_r <= y3_r;

      x5_r <= sat19(x_sh);
      z5_r <= sat19(z_sh);
      y5_r <= y4_r;
    end
  end

  assign out_valid         = vt_r[NT-1];
  assign out_pos_x         = x5_r;
  assign out_pos_y         = y5_r;
  assign out_pos_z         = z5_r;
  assign out_tex_u         = side_r[NT-1].tex_u;
  assign out_tex_v         = side_r[NT-1].tex_v;
  assign out_vertex_number = side_r[NT-1].vtx;
  assign out_last          = (side_r[NT-1].vtx == tcvg_pkg::VTX_LAST);

  // ---------------- checks ----------------
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (busy_r && k_r == tcvg_pkg::VTX_FIRST))
    else $error("cell load did not restart sequencer");

  a_hold_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !en) |=> $stable(k_r))
    else $error("sequencer moved during stall");

  a_ready_en: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> en)
    else $error("input taken while pipeline held");

  a_vtx_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=>
      (out_valid && out_vertex_number == 3'($past(out_vertex_number) + 3'd1)))
    else $error("vertex sequence broken at output");

endmodule
`default_nettype wire
